// ===== rtl/core/conv3x3_replicate_border_macros.svh =====
// ----------------------------------------------------------------------------
// conv3x3_replicate_border assertion macros
// Shared concurrent assertion forms for the 3x3 convolution checker.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_REPLICATE_BORDER_MACROS_SVH
`define CONV3X3_REPLICATE_BORDER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define C3RB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define C3RB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after any cycle with reset applied.
`define C3RB_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/c3rb_pkg.sv =====
// ----------------------------------------------------------------------------
// c3rb_pkg
// Types and constants shared by the 3x3 replicate-border convolution block.
// ----------------------------------------------------------------------------
package c3rb_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int NUM_COLS      = 3;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + COEF_W;
  localparam int CSUM_W = PROD_W + 2;
  localparam int SUM_W  = CSUM_W + 2;

  localparam int KROW_W = NUM_COLS * COEF_W;
  localparam int IW_W   = 11;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  localparam logic [KROW_W-1:0] KERNEL_TOP_RST = 48'd26667960113217;
  localparam logic [KROW_W-1:0] KERNEL_MID_RST = 48'd33303811071562;
  localparam logic [KROW_W-1:0] KERNEL_BOT_RST = 48'd26667960113217;
  localparam logic [IW_W-1:0]   IMAGE_WIDTH_RST = 11'd32;

  localparam int OUTQ_AW    = 3;
  localparam int OUTQ_DEPTH = 1 << OUTQ_AW;
  localparam int OUTQ_CW    = OUTQ_AW + 1;

  typedef enum logic [1:0] {
    REG_KTOP   = 2'd0,
    REG_KMID   = 2'd1,
    REG_KBOT   = 2'd2,
    REG_IWIDTH = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FLUSH = 2'd2,
    OP_EDGE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic [COEF_W-1:0] top;
    logic [COEF_W-1:0] mid;
    logic [COEF_W-1:0] bot;
  } coef_col_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] older_a;
    logic [PIX_W-1:0] newer_a;
    logic [PIX_W-1:0] older_b;
    logic [PIX_W-1:0] newer_b;
  } lb_rd_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             eor;
    logic             eof;
  } result_t;

endpackage

// ===== rtl/core/c3rb_cell.sv =====
// ----------------------------------------------------------------------------
// c3rb_cell
// One window column: three taps, their products and the column sum.
// ----------------------------------------------------------------------------
module c3rb_cell import c3rb_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  col_t              shift_in,
  input  col_t              load_in,
  input  coef_col_t         coef,
  output col_t              taps,
  output logic [CSUM_W-1:0] col_sum
);

  col_t              taps_r;
  col_t              taps_nxt;
  logic [PROD_W-1:0] prod_top_r;
  logic [PROD_W-1:0] prod_mid_r;
  logic [PROD_W-1:0] prod_bot_r;
  logic [CSUM_W-1:0] col_sum_r;

  always_comb begin
    taps_nxt = taps_r;
    if (ctrl.load) begin
      taps_nxt = load_in;
    end else if (ctrl.shift) begin
      taps_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    taps_r     <= taps_nxt;
    prod_top_r <= PROD_W'(taps_r.top) * PROD_W'(coef.top);
    prod_mid_r <= PROD_W'(taps_r.mid) * PROD_W'(coef.mid);
    prod_bot_r <= PROD_W'(taps_r.bot) * PROD_W'(coef.bot);
    col_sum_r  <= CSUM_W'(prod_top_r) + CSUM_W'(prod_mid_r) + CSUM_W'(prod_bot_r);
  end

  assign taps    = taps_r;
  assign col_sum = col_sum_r;

endmodule

// ===== rtl/core/c3rb_linebuf.sv =====
// ----------------------------------------------------------------------------
// c3rb_linebuf
// Two line stores holding the previous two rows, two read ports each.
// ----------------------------------------------------------------------------
module c3rb_linebuf import c3rb_pkg::*; #(
  parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [CW-1:0]    rd_addr_a,
  input  logic [CW-1:0]    rd_addr_b,
  input  logic             newer_we,
  input  logic [CW-1:0]    newer_waddr,
  input  logic [PIX_W-1:0] newer_wdata,
  input  logic             older_we,
  input  logic [CW-1:0]    older_waddr,
  input  logic [PIX_W-1:0] older_wdata,
  output lb_rd_t           rd_data
);

  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  lb_rd_t           rd_data_r;

  // A read issued together with a newer-row write sees the old entry,
  // which is what the window needs.
  always_ff @(posedge clk) begin
    if (newer_we) begin
      newer_mem[newer_waddr] <= newer_wdata;
    end
    if (rd_en) begin
      rd_data_r.newer_a <= newer_mem[rd_addr_a];
      rd_data_r.newer_b <= newer_mem[rd_addr_b];
    end
  end

  // The older row is written in the cycle after the pixel is taken, so a read
  // of the same entry takes the write data directly.
  always_ff @(posedge clk) begin
    if (older_we) begin
      older_mem[older_waddr] <= older_wdata;
    end
    if (rd_en) begin
      rd_data_r.older_a <= (older_we && (older_waddr == rd_addr_a)) ?
                           older_wdata : older_mem[rd_addr_a];
      rd_data_r.older_b <= (older_we && (older_waddr == rd_addr_b)) ?
                           older_wdata : older_mem[rd_addr_b];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/c3rb_outq.sv =====
// ----------------------------------------------------------------------------
// c3rb_outq
// Small result queue between the arithmetic pipeline and the output port.
// ----------------------------------------------------------------------------
module c3rb_outq import c3rb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    valid,
  output result_t head
);

  result_t              q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr_r;
  logic [OUTQ_AW-1:0]   rd_ptr_r;
  logic [OUTQ_CW-1:0]   count_r;
  logic [OUTQ_AW-1:0]   wr_ptr_nxt;
  logic [OUTQ_AW-1:0]   rd_ptr_nxt;
  logic [OUTQ_CW-1:0]   count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OUTQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OUTQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + OUTQ_CW'(push) - OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = (count_r != '0);
  assign head  = q_r[rd_ptr_r];

endmodule

// ===== rtl/core/conv3x3_replicate_border.sv =====
// ----------------------------------------------------------------------------
// conv3x3_replicate_border
// Streaming 3x3 convolution of an 8-bit raster stream, border replicated.
//
// Input transactions carry a command and a pixel. Pixels arrive in raster
// order; from the second row on, each pixel but the first of a row releases
// the result one row up and one column left, and the last pixel of a row
// also releases that row's final result. Flush transactions then drain
// the last row, one result each. Results carry end_of_row and end_of_frame
// markers. The window taps, products and column sums are registered in
// turn, and the second result of a row end is queued behind the first.
// One transaction is taken per cycle while in_stall is low; a row-end pixel
// that releases two results raises in_stall for a single cycle while a
// three-cell window chain shifts for the replicated right border.
// An eight-entry result queue decouples the output; when the receiver
// stalls, in_stall rises once more than six results are reserved and nothing
// is lost.
// Reset restores the default kernel and a width of 32 and clears all
// counters; the line stores are not cleared and need no clearing pass.
// Configuration: 64-bit registers at byte addresses 0, 8, 16 and 24.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border import c3rb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [PIX_W-1:0]  in_pixel_value,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_filtered_value,
  output logic              out_end_of_row,
  output logic              out_end_of_frame,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic valid;
    logic eor;
    logic eof;
  } meta_t;

  // Configuration registers
  logic [KROW_W-1:0] ktop_r;
  logic [KROW_W-1:0] kmid_r;
  logic [KROW_W-1:0] kbot_r;
  logic [IW_W-1:0]   iwidth_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r   <= KERNEL_TOP_RST;
      kmid_r   <= KERNEL_MID_RST;
      kbot_r   <= KERNEL_BOT_RST;
      iwidth_r <= IMAGE_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KTOP:   ktop_r   <= cfg_pwdata[KROW_W-1:0];
        REG_KMID:   kmid_r   <= cfg_pwdata[KROW_W-1:0];
        REG_KBOT:   kbot_r   <= cfg_pwdata[KROW_W-1:0];
        REG_IWIDTH: iwidth_r <= cfg_pwdata[IW_W-1:0];
        default:    ktop_r   <= ktop_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KTOP:   cfg_prdata = CFG_DW'(ktop_r);
      REG_KMID:   cfg_prdata = CFG_DW'(kmid_r);
      REG_KBOT:   cfg_prdata = CFG_DW'(kbot_r);
      REG_IWIDTH: cfg_prdata = CFG_DW'(iwidth_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Last column index of the line in use; a width of zero acts as one.
  logic [CW-1:0] w_last;

  always_comb begin
    if (iwidth_r == '0) begin
      w_last = '0;
    end else if (32'(iwidth_r) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(iwidth_r - 1'b1);
    end
  end

  // Frame position counters. row_r saturates at two: only "none", "one"
  // and "two or more" complete rows matter.
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    row_r, row_nxt;
  logic [CW-1:0] fc_r, fc_nxt;

  // Stage after acceptance: line store data arrives here.
  op_t              s1_op_r, s1_op_nxt;
  logic             s1_edge_r, s1_edge_nxt;
  logic             s1_c0_r, s1_c0_nxt;
  logic             s1_clamp_r, s1_clamp_nxt;
  logic             s1_top2_r, s1_top2_nxt;
  logic             s1_emit_r, s1_emit_nxt;
  logic             s1_eor_r, s1_eor_nxt;
  logic             s1_eof_r, s1_eof_nxt;
  logic [CW-1:0]    s1_addr_r, s1_addr_nxt;
  logic [PIX_W-1:0] s1_pix_r, s1_pix_nxt;

  logic [OUTQ_CW-1:0] credit_r, credit_nxt;

  logic          acc;
  logic          is_pix;
  logic          edge_hold;
  logic          drain_abort;
  logic [CW-1:0] pix_col0;
  logic [1:0]    pix_row;
  logic [CW-1:0] pix_c;
  logic          pix_end;
  logic          pix_first;
  logic          pix_emit1;
  logic          pix_emit2;
  logic          fl_ok;
  logic [CW-1:0] fl_c;
  logic          fl_last;
  logic          fl_clamp;
  logic [CW-1:0] fl_left;
  logic [CW-1:0] fl_right;
  logic [1:0]    n_out;
  logic          pop;

  assign edge_hold = (s1_op_r == OP_PIXEL) && s1_edge_r;
  assign in_stall  = edge_hold || (credit_r > OUTQ_CW'(OUTQ_DEPTH - 2));
  assign acc       = in_valid && !in_stall;
  assign is_pix    = (cmd_t'(in_command) == CMD_PIXEL);

  always_comb begin
    // A pixel arriving during a drain starts a new frame.
    drain_abort = (fc_r != '0);
    pix_col0    = drain_abort ? '0 : col_r;
    pix_row     = drain_abort ? 2'd0 : row_r;
    pix_c       = (pix_col0 > w_last) ? '0 : pix_col0;
    pix_end     = (pix_c == w_last);
    pix_first   = (pix_c == '0);
    pix_emit1   = (pix_row != 2'd0) && !pix_first;
    pix_emit2   = (pix_row != 2'd0) && pix_end;

    fl_ok    = (row_r != 2'd0) && (col_r == '0);
    fl_c     = (fc_r > w_last) ? w_last : fc_r;
    fl_last  = (fl_c == w_last);
    // A drain count beyond a narrowed line cannot slide the window, so the
    // last two columns are read and loaded directly.
    fl_clamp = (fc_r > w_last) && (w_last != '0);
    fl_left  = fl_clamp ? w_last - CW'(1) : fl_c;
    fl_right = fl_last ? fl_c : fl_c + CW'(1);

    col_nxt      = col_r;
    row_nxt      = row_r;
    fc_nxt       = fc_r;
    n_out        = 2'd0;
    s1_op_nxt    = OP_NONE;
    s1_edge_nxt  = 1'b0;
    s1_c0_nxt    = s1_c0_r;
    s1_clamp_nxt = 1'b0;
    s1_top2_nxt  = s1_top2_r;
    s1_emit_nxt  = 1'b0;
    s1_eor_nxt   = 1'b0;
    s1_eof_nxt   = 1'b0;
    s1_addr_nxt  = s1_addr_r;
    s1_pix_nxt   = s1_pix_r;

    if (edge_hold) begin
      // Second result of a row end: window contents shift left, right column repeats.
      s1_op_nxt   = OP_EDGE;
      s1_emit_nxt = 1'b1;
      s1_eor_nxt  = 1'b1;
    end else if (acc && is_pix) begin
      s1_op_nxt   = OP_PIXEL;
      s1_edge_nxt = pix_emit2;
      s1_c0_nxt   = pix_first;
      s1_top2_nxt = pix_row[1];
      s1_emit_nxt = pix_emit1;
      s1_addr_nxt = pix_c;
      s1_pix_nxt  = in_pixel_value;
      n_out       = {1'b0, pix_emit1} + {1'b0, pix_emit2};
      fc_nxt      = '0;
      if (pix_end) begin
        col_nxt = '0;
        row_nxt = pix_row[1] ? pix_row : pix_row + 2'd1;
      end else begin
        col_nxt = pix_c + CW'(1);
        row_nxt = pix_row;
      end
    end else if (acc && fl_ok) begin
      s1_op_nxt    = OP_FLUSH;
      s1_c0_nxt    = (fl_c == '0);
      s1_clamp_nxt = fl_clamp;
      s1_top2_nxt  = row_r[1];
      s1_emit_nxt  = 1'b1;
      s1_eor_nxt   = fl_last;
      s1_eof_nxt   = fl_last;
      n_out        = 2'd1;
      if (fl_last) begin
        fc_nxt  = '0;
        row_nxt = 2'd0;
        col_nxt = '0;
      end else begin
        fc_nxt = fl_c + CW'(1);
      end
    end
  end

  assign pop        = out_valid && !out_stall;
  assign credit_nxt = credit_r + OUTQ_CW'(n_out) - OUTQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= 2'd0;
      fc_r      <= '0;
      s1_op_r   <= OP_NONE;
      s1_edge_r <= 1'b0;
      credit_r  <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      fc_r      <= fc_nxt;
      s1_op_r   <= s1_op_nxt;
      s1_edge_r <= s1_edge_nxt;
      credit_r  <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_c0_r    <= s1_c0_nxt;
    s1_clamp_r <= s1_clamp_nxt;
    s1_top2_r  <= s1_top2_nxt;
    s1_emit_r  <= s1_emit_nxt;
    s1_eor_r   <= s1_eor_nxt;
    s1_eof_r   <= s1_eof_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_pix_r   <= s1_pix_nxt;
  end

  // Line stores
  lb_rd_t lb_rd;

  c3rb_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk         (clk),
    .rd_en       (acc && (is_pix || fl_ok)),
    .rd_addr_a   (is_pix ? pix_c : fl_left),
    .rd_addr_b   (fl_right),
    .newer_we    (acc && is_pix),
    .newer_waddr (pix_c),
    .newer_wdata (in_pixel_value),
    .older_we    (s1_op_r == OP_PIXEL),
    .older_waddr (s1_addr_r),
    .older_wdata (lb_rd.newer_a),
    .rd_data     (lb_rd)
  );

  // New window columns. Rows above the frame repeat the top row; a flush
  // repeats the last row as the row below.
  col_t col_a;
  col_t col_b;
  logic s1_active;
  logic s1_loads;

  always_comb begin
    col_a.top = s1_top2_r ? lb_rd.older_a : lb_rd.newer_a;
    col_a.mid = lb_rd.newer_a;
    col_a.bot = (s1_op_r == OP_PIXEL) ? s1_pix_r : lb_rd.newer_a;
    col_b.top = s1_top2_r ? lb_rd.older_b : lb_rd.newer_b;
    col_b.mid = lb_rd.newer_b;
    col_b.bot = lb_rd.newer_b;
    s1_active = (s1_op_r != OP_NONE);
    s1_loads  = (s1_op_r == OP_PIXEL) || (s1_op_r == OP_FLUSH);
  end

  // Window chain: cell 0 is the left column, cell 2 the right one.
  col_t              taps_w  [NUM_COLS];
  logic [CSUM_W-1:0] colsum_w [NUM_COLS];

  for (genvar j = 0; j < NUM_COLS; j++) begin : g_cell
    cell_ctrl_t ctrl;
    col_t       load_in;
    col_t       shift_in;
    coef_col_t  coef;

    always_comb begin
      coef.top = ktop_r[j*COEF_W +: COEF_W];
      coef.mid = kmid_r[j*COEF_W +: COEF_W];
      coef.bot = kbot_r[j*COEF_W +: COEF_W];
    end

    if (j == NUM_COLS - 1) begin : g_right
      always_comb begin
        ctrl.load  = s1_loads;
        ctrl.shift = 1'b0;
        load_in    = (s1_op_r == OP_PIXEL) ? col_a : col_b;
        shift_in   = taps_w[j];
      end
    end else begin : g_inner
      // At column zero the inner cells are filled with the border column; a clamped drain loads them directly too.
      always_comb begin
        ctrl.load  = s1_loads && (s1_c0_r || s1_clamp_r);
        ctrl.shift = s1_active && !(s1_loads && (s1_c0_r || s1_clamp_r));
        load_in    = ((j == NUM_COLS - 2) && s1_clamp_r) ? col_b : col_a;
        shift_in   = taps_w[j+1];
      end
    end

    c3rb_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .shift_in (shift_in),
      .load_in  (load_in),
      .coef     (coef),
      .taps     (taps_w[j]),
      .col_sum  (colsum_w[j])
    );
  end

  // Result tags follow the products and column sums through the cells.
  meta_t m1_r, m2_r, m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
      m2_r <= '0;
      m3_r <= '0;
    end else begin
      m1_r.valid <= s1_active && s1_emit_r;
      m1_r.eor   <= s1_eor_r;
      m1_r.eof   <= s1_eof_r;
      m2_r       <= m1_r;
      m3_r       <= m2_r;
    end
  end

  logic [SUM_W-1:0]        sum_all;
  logic [SUM_W-COEF_W-1:0] sum_int;
  result_t                 res;

  always_comb begin
    sum_all   = SUM_W'(colsum_w[0]) + SUM_W'(colsum_w[1]) + SUM_W'(colsum_w[2]);
    sum_int   = sum_all[SUM_W-1:COEF_W];
    res.value = (|sum_int[SUM_W-COEF_W-1:PIX_W]) ? '1 : sum_int[PIX_W-1:0];
    res.eor   = m3_r.eor;
    res.eof   = m3_r.eof;
  end

  result_t head;

  c3rb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (m3_r.valid),
    .push_data (res),
    .pop       (pop),
    .valid     (out_valid),
    .head      (head)
  );

  assign out_filtered_value = head.value;
  assign out_end_of_row     = head.eor;
  assign out_end_of_frame   = head.eof;

endmodule

// ===== rtl/core/c3rb_checker.sv =====
// ----------------------------------------------------------------------------
// c3rb_checker
// Port-level checks of the 3x3 convolution block, bound to its top level.
// ----------------------------------------------------------------------------
`include "conv3x3_replicate_border_macros.svh"

module c3rb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_filtered_value,
  input logic       out_end_of_row,
  input logic       out_end_of_frame,
  input logic       cfg_pready
);

  // A stalled result stays offered and unchanged.
  `C3RB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_filtered_value) && $stable(out_end_of_row) && $stable(out_end_of_frame), "stalled result changed or dropped")

  // The last result of a frame also closes its row.
  `C3RB_ASSERT_IMPL(a_eof_eor, clk, rst_n, out_valid && out_end_of_frame, out_end_of_row, "end of frame without end of row")

  `C3RB_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, cfg_pready, "configuration port not ready")

  // Nothing is offered right after reset.
  `C3RB_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid, "result offered after reset")

endmodule

bind conv3x3_replicate_border c3rb_checker u_c3rb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_filtered_value (out_filtered_value),
  .out_end_of_row     (out_end_of_row),
  .out_end_of_frame   (out_end_of_frame),
  .cfg_pready         (cfg_pready)
);
